>>> src/pbn_pkg.sv
// Shared constants, types and helpers for the palette blend / nearest color unit.
`default_nettype none
package pbn_pkg;

    localparam int PALETTE_ENTRIES = 256;
    localparam int QUANT_BITS      = 5;
    localparam int IDX_W           = 8;
    localparam int CH_W            = 8;
    localparam int DIST_W          = 18;
    localparam int NUM_CELLS       = 3;

    typedef enum logic [2:0] {
        CMD_WRITE   = 3'd0,
        CMD_NEAREST = 3'd1,
        CMD_LIGHTEN = 3'd2,
        CMD_DARKEN  = 3'd3,
        CMD_ALPHA25 = 3'd4,
        CMD_ALPHA50 = 3'd5,
        CMD_ALPHA75 = 3'd6,
        CMD_NONE    = 3'd7
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RDF,
        ST_RDB,
        ST_MIX,
        ST_SCAN,
        ST_DRAIN,
        ST_OUT
    } state_t;

    // One beat travelling down the chain of distance cells
    typedef struct packed {
        logic              vld;
        logic              last;
        logic [IDX_W-1:0]  idx;
        logic [DIST_W-1:0] dsum;
    } link_t;

    // Clip the low bits of a channel to the quantizer grid
    function automatic logic [CH_W-1:0] quant(input logic [CH_W-1:0] v);
        logic [CH_W-1:0] mask;
        mask = ~((CH_W'(1) << (CH_W - QUANT_BITS)) - CH_W'(1));
        return v & mask;
    endfunction

endpackage
`default_nettype wire

>>> src/palette_blend_nearest_color.sv
// Top level: palette memory, command sequencer and the distance cell chain.
//
//  channel | valid    | stall     | payload
//  in      | in_valid | in_stall  | cmd entry_index red green blue front_index back_index
//  out     | out_valid| out_stall | result_index
//
// A write stores the entry on accept, leaving the sequencer idle. Lighten and darken read
// the front and back entries and compare them. Alpha reads and mixes them, then scans like
// nearest: one palette read per cycle over entries 1..255, through three channel cells and
// a min stage. Reset clears the palette by one entry a cycle; no item is taken meanwhile.
// The result waits in an output register; a stall on it holds the sequencer.
`default_nettype none
module palette_blend_nearest_color
    import pbn_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output      logic             in_stall,
    input  wire logic [2:0]       cmd,
    input  wire logic [7:0]       entry_index,
    input  wire logic [7:0]       red,
    input  wire logic [7:0]       green,
    input  wire logic [7:0]       blue,
    input  wire logic [7:0]       front_index,
    input  wire logic [7:0]       back_index,
    output      logic             out_valid,
    input  wire logic             out_stall,
    output      logic [7:0]       result_index
);

    logic [23:0]      mem [PALETTE_ENTRIES];
    logic [23:0]      rd_reg;
    logic [IDX_W:0]   clr_reg;
    logic             clearing;
    state_t           state_reg, state_next;
    cmd_t             cmd_reg;
    logic [IDX_W-1:0] fi_reg, bi_reg, scan_reg;
    logic [CH_W-1:0]  tr_reg, tg_reg, tb_reg;
    logic [23:0]      fe_reg;
    logic [IDX_W-1:0] res_reg;
    logic             ov_reg;
    logic             accept;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             rd_vld_reg, rd_last_reg;
    logic [IDX_W-1:0] rd_idx_reg;
    logic             last_scan;
    link_t            l0, l1, l2, l3;
    logic             min_start, min_done;
    logic [IDX_W-1:0] min_best;
    logic [17:0]      ef, eb;
    logic [9:0]       mr, mg, mb;
    logic [23:0]      e1_reg, e2_reg;

    assign clearing = !clr_reg[IDX_W];
    assign in_stall = clearing || (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign last_scan = (scan_reg == IDX_W'(PALETTE_ENTRIES - 1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (accept)
                begin
                    case (cmd_t'(cmd))
                        CMD_WRITE, CMD_NONE: state_next = ST_IDLE;
                        CMD_NEAREST:         state_next = ST_SCAN;
                        default:             state_next = ST_RDF;
                    endcase
                end
            ST_RDF:   state_next = ST_RDB;
            ST_RDB:   state_next = ST_MIX;
            ST_MIX:   state_next = (cmd_reg == CMD_LIGHTEN || cmd_reg == CMD_DARKEN)
                                   ? ST_OUT : ST_SCAN;
            ST_SCAN:  state_next = last_scan ? ST_DRAIN : ST_SCAN;
            ST_DRAIN: state_next = min_done ? ST_OUT : ST_DRAIN;
            ST_OUT:   state_next = (ov_reg && !out_stall) ? ST_IDLE : ST_OUT;
            default:  state_next = ST_IDLE;
        endcase
    end

    // memory read address per state
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = scan_reg;
        unique case (state_reg)
            ST_RDF:  begin rd_en = 1'b1; rd_addr = fi_reg; end
            ST_RDB:  begin rd_en = 1'b1; rd_addr = bi_reg; end
            ST_SCAN: begin rd_en = 1'b1; rd_addr = scan_reg; end
            default: begin rd_en = 1'b0; rd_addr = scan_reg; end
        endcase
    end

    assign min_start = accept || (state_reg == ST_MIX);

    // palette memory: clearing sweep, writes and registered reads
    always_ff @(posedge clk)
    begin
        if (clearing)
        begin
            mem[clr_reg[IDX_W-1:0]] <= '0;
        end
        else if (accept && cmd_t'(cmd) == CMD_WRITE)
        begin
            mem[entry_index] <= {red, green, blue};
        end
        if (rd_en)
        begin
            rd_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg     <= '0;
            state_reg   <= ST_IDLE;
            ov_reg      <= 1'b0;
            rd_vld_reg  <= 1'b0;
        end
        else
        begin
            if (clearing)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            state_reg  <= state_next;
            rd_vld_reg <= (state_reg == ST_SCAN);
            if (ov_reg && !out_stall)
            begin
                ov_reg <= 1'b0;
            end
            else if (state_reg == ST_OUT && !ov_reg)
            begin
                ov_reg <= 1'b1;
            end
        end
    end

    // squared sums for lighten/darken, floor mixes for alpha
    assign ef = 18'(fe_reg[23:16] * fe_reg[23:16]) + 18'(fe_reg[15:8] * fe_reg[15:8])
              + 18'(fe_reg[7:0] * fe_reg[7:0]);
    assign eb = 18'(rd_reg[23:16] * rd_reg[23:16]) + 18'(rd_reg[15:8] * rd_reg[15:8])
              + 18'(rd_reg[7:0] * rd_reg[7:0]);

    always_comb
    begin
        case (cmd_reg)
            CMD_ALPHA25:
            begin
                mr = (10'(fe_reg[23:16]) + 10'(rd_reg[23:16]) * 10'd3) >> 2;
                mg = (10'(fe_reg[15:8])  + 10'(rd_reg[15:8])  * 10'd3) >> 2;
                mb = (10'(fe_reg[7:0])   + 10'(rd_reg[7:0])   * 10'd3) >> 2;
            end
            CMD_ALPHA75:
            begin
                mr = (10'(fe_reg[23:16]) * 10'd3 + 10'(rd_reg[23:16])) >> 2;
                mg = (10'(fe_reg[15:8])  * 10'd3 + 10'(rd_reg[15:8])) >> 2;
                mb = (10'(fe_reg[7:0])   * 10'd3 + 10'(rd_reg[7:0])) >> 2;
            end
            default:
            begin
                mr = (10'(fe_reg[23:16]) + 10'(rd_reg[23:16])) >> 1;
                mg = (10'(fe_reg[15:8])  + 10'(rd_reg[15:8])) >> 1;
                mb = (10'(fe_reg[7:0])   + 10'(rd_reg[7:0])) >> 1;
            end
        endcase
    end

    // hold command fields, targets, scan index and result
    always_ff @(posedge clk)
    begin
        rd_idx_reg  <= scan_reg;
        rd_last_reg <= last_scan;
        if (accept)
        begin
            cmd_reg  <= cmd_t'(cmd);
            fi_reg   <= front_index;
            bi_reg   <= back_index;
            tr_reg   <= red;
            tg_reg   <= green;
            tb_reg   <= blue;
            scan_reg <= IDX_W'(1);
        end
        else if (state_reg == ST_SCAN)
        begin
            scan_reg <= scan_reg + 1'b1;
        end
        if (state_reg == ST_RDB)
        begin
            fe_reg <= rd_reg;
        end
        if (state_reg == ST_MIX)
        begin
            scan_reg <= IDX_W'(1);
            if (cmd_reg == CMD_LIGHTEN)
            begin
                res_reg <= (ef > eb) ? fi_reg : bi_reg;
            end
            else if (cmd_reg == CMD_DARKEN)
            begin
                res_reg <= (ef < eb) ? fi_reg : bi_reg;
            end
            tr_reg <= quant(mr[7:0]);
            tg_reg <= quant(mg[7:0]);
            tb_reg <= quant(mb[7:0]);
        end
        if (state_reg == ST_DRAIN && min_done)
        begin
            res_reg <= min_best;
        end
    end

    // feed the chain: entry data follows in a parallel delay line
    always_comb
    begin
        l0      = '0;
        l0.vld  = rd_vld_reg;
        l0.last = rd_last_reg;
        l0.idx  = rd_idx_reg;
    end

    always_ff @(posedge clk)
    begin
        e1_reg <= rd_reg;
        e2_reg <= e1_reg;
    end

    pbn_cell u_cell_r (.clk, .rst_n, .ent_in(rd_reg), .target(tr_reg), .sel(2'd0),
                       .link_in(l0), .link_out(l1));
    pbn_cell u_cell_g (.clk, .rst_n, .ent_in(e1_reg), .target(tg_reg), .sel(2'd1),
                       .link_in(l1), .link_out(l2));
    pbn_cell u_cell_b (.clk, .rst_n, .ent_in(e2_reg), .target(tb_reg), .sel(2'd2),
                       .link_in(l2), .link_out(l3));

    pbn_min u_min (.clk, .rst_n, .start(min_start), .link_in(l3),
                   .done(min_done), .best(min_best));

    assign out_valid    = ov_reg;
    assign result_index = res_reg;

endmodule
`default_nettype wire

>>> src/pbn_cell.sv
// One distance cell: adds the squared difference of one channel and hands the beat on.
`default_nettype none
module pbn_cell
    import pbn_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic [23:0]     ent_in,
    input  wire logic [CH_W-1:0] target,
    input  wire logic [1:0]      sel,
    input  wire link_t           link_in,
    output      link_t           link_out
);

    logic [CH_W-1:0]   ch;
    logic [CH_W-1:0]   diff;
    logic [DIST_W-1:0] sq;
    link_t             link_reg;
    link_t             link_next;

    // pick the channel this cell owns and square its difference
    always_comb
    begin
        case (sel)
            2'd0:    ch = ent_in[23:16];
            2'd1:    ch = ent_in[15:8];
            default: ch = ent_in[7:0];
        endcase
        diff = (ch > target) ? (ch - target) : (target - ch);
        sq   = DIST_W'(diff * diff);
        link_next      = link_in;
        link_next.dsum = link_in.dsum + sq;
    end

    // advance the beat, valid cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_reg <= '0;
        end
        else
        begin
            link_reg <= link_next;
        end
    end

    assign link_out = link_reg;

endmodule
`default_nettype wire

>>> src/pbn_min.sv
// Running minimum over the distance beats coming out of the chain.
`default_nettype none
module pbn_min
    import pbn_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire link_t            link_in,
    output      logic             done,
    output      logic [IDX_W-1:0] best
);

    logic [DIST_W-1:0] best_dist_reg;
    logic [IDX_W-1:0]  best_reg;
    logic              have_reg;
    logic              done_reg;
    logic              take;

    // strictly smaller wins, so ties keep the lowest index
    assign take = link_in.vld && (!have_reg || link_in.dsum < best_dist_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            have_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                have_reg <= 1'b1;
            end
            done_reg <= link_in.vld && link_in.last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            best_reg <= IDX_W'(1);
        end
        else if (take)
        begin
            best_reg      <= link_in.idx;
            best_dist_reg <= link_in.dsum;
        end
    end

    assign done = done_reg;
    assign best = best_reg;

endmodule
`default_nettype wire

>>> tb/tb_top.sv
// Testbench for the palette blend and nearest color unit.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
    import pbn_pkg::*;

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] eidx;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] fi;
        logic [7:0] bi;
    } beat_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [2:0] cmd = '0;
    logic [7:0] entry_index = '0;
    logic [7:0] red = '0;
    logic [7:0] green = '0;
    logic [7:0] blue = '0;
    logic [7:0] front_index = '0;
    logic [7:0] back_index = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] result_index;

    beat_t      pending_beats[$];
    logic [7:0] expected_index[$];
    logic [23:0] pal_model[256];
    int  mismatches = 0;
    int  cycle_count = 0;
    int  hold_cycles = 0;
    bit  no_idle = 1'b0;
    bit  pause_tx = 1'b0;
    bit  in_accepted = 1'b0;

    always #6 clk = ~clk;

    palette_blend_nearest_color u_top (.*);

    task automatic report(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d want %0d at cycle %0d", what, got, want, cycle_count);
        mismatches++;
    endtask

    function automatic logic [7:0] nearest_entry(input logic [7:0] r, input logic [7:0] g,
                                                  input logic [7:0] b);
        int best;
        int best_d;
        int d;
        best = 1;
        best_d = 32'h7fffffff;
        for (int i = 1; i < PALETTE_ENTRIES; i++)
        begin
            d = (int'(pal_model[i][23:16]) - int'(r)) ** 2
                + (int'(pal_model[i][15:8]) - int'(g)) ** 2
                + (int'(pal_model[i][7:0]) - int'(b)) ** 2;
            if (d < best_d)
            begin
                best_d = d;
                best = i;
            end
        end
        return 8'(best);
    endfunction

    function automatic int energy(input logic [23:0] e);
        return int'(e[23:16]) ** 2 + int'(e[15:8]) ** 2 + int'(e[7:0]) ** 2;
    endfunction

    // Update the palette copy and queue the answer for one accepted beat
    task automatic predict_blend(input beat_t t);
        logic [23:0] fe;
        logic [23:0] be;
        logic [7:0]  m[3];
        int wf;
        int wk;
        int sh;
        fe = pal_model[t.fi];
        be = pal_model[t.bi];
        case (cmd_t'(t.cmd))
            CMD_WRITE: pal_model[t.eidx] = {t.r, t.g, t.b};
            CMD_NONE: ;
            CMD_NEAREST: expected_index.push_back(nearest_entry(t.r, t.g, t.b));
            CMD_LIGHTEN: expected_index.push_back(energy(fe) > energy(be) ? t.fi : t.bi);
            CMD_DARKEN: expected_index.push_back(energy(fe) < energy(be) ? t.fi : t.bi);
            default:
            begin
                if (t.cmd == CMD_ALPHA25) begin wf = 1; wk = 3; sh = 2; end
                else if (t.cmd == CMD_ALPHA50) begin wf = 1; wk = 1; sh = 1; end
                else begin wf = 3; wk = 1; sh = 2; end
                for (int c = 0; c < 3; c++)
                begin
                    m[c] = 8'((wf * int'(fe[8*c +: 8]) + wk * int'(be[8*c +: 8])) >> sh);
                    m[c] = m[c] & ~8'((1 << (8 - QUANT_BITS)) - 1);
                end
                expected_index.push_back(nearest_entry(m[2], m[1], m[0]));
            end
        endcase
    endtask

    function automatic beat_t rand_beat(input logic [2:0] c);
        beat_t t;
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        t = raw[$bits(beat_t)-1:0];
        t.cmd = c;
        return t;
    endfunction

    // Driver: present beats from the queue at the falling edge
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_accepted))
        begin
            if (pending_beats.size() > 0 && !pause_tx &&
                (no_idle || $urandom_range(99) >= 9))
            begin
                {cmd, entry_index, red, green, blue, front_index, back_index} =
                    pending_beats.pop_front();
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver stall: long hold-off or random idling
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= !no_idle && ($urandom_range(99) < 9);
    end

    // Monitor: predict accepted inputs, check accepted results
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        in_accepted <= in_valid && !in_stall;
        if (in_valid && !in_stall)
            predict_blend({cmd, entry_index, red, green, blue, front_index, back_index});
        if (out_valid && !out_stall)
        begin
            if (expected_index.size() == 0)
                report("unexpected result", result_index, -1);
            else if (result_index !== expected_index[0])
                report("result_index", result_index, expected_index.pop_front());
            else
                void'(expected_index.pop_front());
        end
        if (cycle_count > 2000000)
        begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    task automatic wait_drain();
        while (pending_beats.size() > 0 || in_valid || expected_index.size() > 0)
            @(posedge clk);
    endtask

    initial
    begin
        logic [2:0] c;
        beat_t t;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        // Directed: extremes, every command, tie and empty cases
        pending_beats.push_back(rand_beat(CMD_NEAREST));          // all black palette
        t = '0; t.cmd = CMD_LIGHTEN; pending_beats.push_back(t);   // tie keeps back
        t.cmd = CMD_DARKEN; t.fi = 8'hff; pending_beats.push_back(t);
        t = '0; t.cmd = CMD_WRITE; t.eidx = 8'hff; t.r = 8'hff; t.g = 8'hff; t.b = 8'hff;
        pending_beats.push_back(t);
        t.eidx = 8'h00; t.r = 8'hff; t.g = 8'h00; t.b = 8'h00; pending_beats.push_back(t);
        t.eidx = 8'h05; t.r = 8'h10; t.g = 8'h80; t.b = 8'h7f; pending_beats.push_back(t);
        t.cmd = CMD_NEAREST; t.r = 8'hff; t.g = 8'h00; t.b = 8'h00; pending_beats.push_back(t);
        t.r = 8'hff; t.g = 8'hff; t.b = 8'hff; pending_beats.push_back(t);
        for (int k = CMD_LIGHTEN; k <= CMD_ALPHA75; k++)
        begin
            t = '0; t.cmd = 3'(k); t.fi = 8'hff; t.bi = 8'h05; pending_beats.push_back(t);
            t.fi = 8'h00; t.bi = 8'hff; pending_beats.push_back(t);
        end
        pending_beats.push_back(rand_beat(CMD_NONE));
        pending_beats.push_back(rand_beat(CMD_NEAREST));
        wait_drain();
        // Fill the palette randomly, clustered so ties happen too
        for (int i = 0; i < 256; i++)
        begin
            t = rand_beat(CMD_WRITE);
            t.eidx = 8'(i);
            if (i % 4 == 0) begin t.r &= 8'he0; t.g &= 8'he0; t.b &= 8'he0; end
            pending_beats.push_back(t);
        end
        // Hold the receiver off while the sender keeps offering
        no_idle = 1'b1;
        for (int i = 0; i < 6; i++)
            pending_beats.push_back(rand_beat(3'($urandom_range(CMD_LIGHTEN, CMD_DARKEN))));
        wait (pending_beats.size() < 4);
        hold_cycles = 2000;
        wait_drain();
        no_idle = 1'b0;
        // Random: mostly queries, some writes and unused commands
        for (int n = 0; n < 1550; n++)
        begin
            if (n == 700) no_idle = 1'b1;
            if (n == 900) no_idle = 1'b0;
            if (n == 1000)
            begin
                while (pending_beats.size() > 0) @(posedge clk);
                pause_tx = 1'b1;
                wait_drain();
                pause_tx = 1'b0;
            end
            c = 3'($urandom_range(0, 7));
            t = rand_beat(c);
            if ($urandom_range(3) == 0)
                begin t.r &= 8'hf8; t.g &= 8'hf8; t.b &= 8'hf8; end
            pending_beats.push_back(t);
            while (pending_beats.size() > 8) @(posedge clk);
        end
        wait_drain();
        repeat (600) @(posedge clk);
        if (mismatches == 0 && expected_index.size() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end
endmodule
`default_nettype wire
